/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/maxpool_pkg.sv */
// ----------------------------------------------------------------------------
// maxpool_pkg
// Shared constants and helpers for the 2x2 stride-2 max pooling block.
// ----------------------------------------------------------------------------
package maxpool_pkg;

    localparam int unsigned DEFAULT_MAX_WIDTH   = 1024;
    localparam int unsigned DEFAULT_MAX_HEIGHT  = 1024;
    localparam int unsigned DEFAULT_SAMPLE_BITS = 16;

    // configuration port
    localparam int unsigned CFG_DATA_BITS  = 11;
    localparam int unsigned CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] RESET_FRAME_DIM = 11'd1024;

    // winner position codes
    localparam logic [1:0] POS_TOP_LEFT     = 2'd0;
    localparam logic [1:0] POS_TOP_RIGHT    = 2'd1;
    localparam logic [1:0] POS_BOTTOM_LEFT  = 2'd2;
    localparam logic [1:0] POS_BOTTOM_RIGHT = 2'd3;

    // Sizes below two act as two; sizes above the build maximum act as it.
    function automatic int unsigned clamp_dim(input logic [CFG_DATA_BITS-1:0] v,
                                              input int unsigned hi);
        int unsigned val;
        val = int'(v);
        if (val < 2)
            return 2;
        else if (val > hi)
            return hi;
        else
            return val;
    endfunction

endpackage

/* rtl/core/max_pool_2x2_stride2.sv */
// ----------------------------------------------------------------------------
// max_pool_2x2_stride2
// Streams raster-order samples and emits the maximum and winner position of
// every 2x2 stride-2 window; a line store keeps each column pair's top-row
// maximum between the two rows of a row pair.
//
//   channel | signals                                   | beat when
//   --------+-------------------------------------------+--------------------
//   in      | in_valid, in_stall, sample                | valid && !stall
//   out     | out_valid, out_stall, pooled_max,         | valid && !stall
//           | winner_pos, frame_end                     |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
// One sample per cycle while in_stall is low. A window result appears in the
// output register in the cycle after its bottom-right sample is taken.
// The line store is one RAM: the top row writes a pair on its right sample,
// the bottom row reads it on its left sample, so the read data is ready for
// the compare when the right sample arrives. No clearing pass after reset.
// in_stall rises only when the next sample completes a window while the
// output register is full and stalled. cfg_ready is always high.
// ----------------------------------------------------------------------------
module max_pool_2x2_stride2 #(
    parameter int unsigned MAX_WIDTH   = maxpool_pkg::DEFAULT_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT  = maxpool_pkg::DEFAULT_MAX_HEIGHT,
    parameter int unsigned SAMPLE_BITS = maxpool_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // sample stream
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [SAMPLE_BITS-1:0]            sample,
    // pooled stream
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [SAMPLE_BITS-1:0]            pooled_max,
    output logic [1:0]                               winner_pos,
    output logic                                     frame_end,
    // configuration
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [maxpool_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [maxpool_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int unsigned COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned ROW_W      = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned WDIM_W     = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HDIM_W     = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
    localparam int unsigned LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned LINE_BITS  = SAMPLE_BITS + 1;

    // frame size, stored already clamped
    logic [WDIM_W-1:0] width_reg;
    logic [HDIM_W-1:0] height_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic signed [SAMPLE_BITS-1:0] pair_max_reg, pair_max_next;
    logic                          pair_right_reg, pair_right_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] pooled_max_reg, pooled_max_next;
    logic [1:0]                    winner_pos_reg, winner_pos_next;
    logic                          frame_end_reg, frame_end_next;

    logic                  in_beat;
    logic                  cfg_beat;
    logic [WDIM_W-1:0]     width_even;
    logic [HDIM_W-1:0]     height_even;
    logic [WDIM_W-1:0]     col_plus;
    logic [HDIM_W-1:0]     row_plus;
    logic                  in_window;
    logic                  last_col;
    logic                  last_row;
    logic                  completes_window;
    logic                  sample_gt;
    logic signed [SAMPLE_BITS-1:0] cur_max;
    logic                  cur_right;
    logic signed [SAMPLE_BITS-1:0] top_max;
    logic                  top_right;

    logic                  line_wr_en;
    logic                  line_rd_en;
    logic [LINE_AW-1:0]    line_addr;
    logic [LINE_BITS-1:0]  line_wr_data;
    logic [LINE_BITS-1:0]  line_rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign in_beat   = in_valid && !in_stall;

    assign width_even  = {width_reg[WDIM_W-1:1], 1'b0};
    assign height_even = {height_reg[HDIM_W-1:1], 1'b0};
    assign col_plus    = WDIM_W'(col_reg) + WDIM_W'(1);
    assign row_plus    = HDIM_W'(row_reg) + HDIM_W'(1);

    // odd last column and odd last row fall outside every window
    assign in_window = (WDIM_W'(col_reg) < width_even) && (HDIM_W'(row_reg) < height_even);
    assign last_col  = (col_plus == width_reg);
    assign last_row  = (row_plus == height_reg);

    assign completes_window = in_window && col_reg[0] && row_reg[0];

    // hold the input only when this beat would overwrite a waiting result
    assign in_stall = out_valid_reg && out_stall && completes_window;

    // column pair compare: right sample wins only when strictly greater
    assign sample_gt = sample > pair_max_reg;
    assign cur_max   = sample_gt ? sample : pair_max_reg;
    assign cur_right = sample_gt ? 1'b1 : pair_right_reg;

    assign line_addr    = LINE_AW'(col_reg >> 1);
    assign line_wr_data = {cur_right, cur_max};
    assign line_wr_en   = in_beat && in_window && col_reg[0] && !row_reg[0];
    // prefetch the top-row pair on the bottom row's left sample
    assign line_rd_en   = in_beat && in_window && !col_reg[0] && row_reg[0];

    assign top_max   = $signed(line_rd_data[SAMPLE_BITS-1:0]);
    assign top_right = line_rd_data[SAMPLE_BITS];

    maxpool_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_addr),
        .wr_data (line_wr_data),
        .rd_en   (line_rd_en),
        .rd_addr (line_addr),
        .rd_data (line_rd_data)
    );

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        pair_max_next   = pair_max_reg;
        pair_right_next = pair_right_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pooled_max_next = pooled_max_reg;
        winner_pos_next = winner_pos_reg;
        frame_end_next  = frame_end_reg;

        if (in_beat)
        begin
            if (in_window)
            begin
                if (!col_reg[0])
                begin
                    pair_max_next   = sample;
                    pair_right_next = 1'b0;
                end
                else
                begin
                    pair_max_next   = cur_max;
                    pair_right_next = cur_right;
                end
            end

            if (completes_window)
            begin
                out_valid_next = 1'b1;
                if (cur_max > top_max)
                begin
                    pooled_max_next = cur_max;
                    winner_pos_next = cur_right ? maxpool_pkg::POS_BOTTOM_RIGHT
                                                : maxpool_pkg::POS_BOTTOM_LEFT;
                end
                else
                begin
                    pooled_max_next = top_max;
                    winner_pos_next = top_right ? maxpool_pkg::POS_TOP_RIGHT
                                                : maxpool_pkg::POS_TOP_LEFT;
                end
                frame_end_next = (col_plus == width_even) && (row_plus == height_even);
            end

            // advance the raster position, wrap at the frame end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : ROW_W'(row_plus);
            end
            else
            begin
                col_next = COL_W'(col_plus);
            end
        end

        // any configuration write restarts the frame
        if (cfg_beat)
        begin
            col_next        = '0;
            row_next        = '0;
            pair_max_next   = '0;
            pair_right_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WDIM_W'(maxpool_pkg::clamp_dim(maxpool_pkg::RESET_FRAME_DIM,
                                                             MAX_WIDTH));
            height_reg     <= HDIM_W'(maxpool_pkg::clamp_dim(maxpool_pkg::RESET_FRAME_DIM,
                                                             MAX_HEIGHT));
            col_reg        <= '0;
            row_reg        <= '0;
            pair_max_reg   <= '0;
            pair_right_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_beat)
            begin
                unique case (cfg_index)
                    maxpool_pkg::REG_FRAME_WIDTH:
                    begin
                        width_reg <= WDIM_W'(maxpool_pkg::clamp_dim(cfg_data, MAX_WIDTH));
                    end
                    maxpool_pkg::REG_FRAME_HEIGHT:
                    begin
                        height_reg <= HDIM_W'(maxpool_pkg::clamp_dim(cfg_data, MAX_HEIGHT));
                    end
                    default:
                    begin
                        // index beyond the list: restart only
                    end
                endcase
            end
            col_reg        <= col_next;
            row_reg        <= row_next;
            pair_max_reg   <= pair_max_next;
            pair_right_reg <= pair_right_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pooled_max_reg <= pooled_max_next;
        winner_pos_reg <= winner_pos_next;
        frame_end_reg  <= frame_end_next;
    end

    assign out_valid  = out_valid_reg;
    assign pooled_max = pooled_max_reg;
    assign winner_pos = winner_pos_reg;
    assign frame_end  = frame_end_reg;

endmodule

/* rtl/core/maxpool_ram.sv */
// ----------------------------------------------------------------------------
// maxpool_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module maxpool_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 512,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/maxpool_checker.sv */
// ----------------------------------------------------------------------------
// maxpool_checker
// Port-level checks for max_pool_2x2_stride2, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module maxpool_checker #(
    parameter int unsigned SAMPLE_BITS = maxpool_pkg::DEFAULT_SAMPLE_BITS
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [SAMPLE_BITS-1:0]          pooled_max,
    input logic [1:0]                             winner_pos,
    input logic                                   frame_end,
    input logic                                   cfg_valid,
    input logic                                   cfg_ready
);

    // a stalled result holds its beat
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(pooled_max) && $stable(winner_pos) && $stable(frame_end))

    // input stalls only behind a full, stalled output register
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // a new result needs a sample beat on the edge before
    `ASSERT_IMPLIES(a_out_from_beat, clk, rst_n, $rose(out_valid),
        $past(in_valid) && !$past(in_stall))

    // the configuration port never back-pressures
    `ASSERT_IMPLIES(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind max_pool_2x2_stride2 maxpool_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_maxpool_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x2 stride-2 max pooling block. Streams
// raster-order samples under random gaps and output back-pressure, keeps its
// own model of the line store, pair state and frame counters, and checks
// every pooled beat field by field against a queue of predicted windows.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned SAMPLE_W       = maxpool_pkg::DEFAULT_SAMPLE_BITS;
    localparam int unsigned MAX_W          = maxpool_pkg::DEFAULT_MAX_WIDTH;
    localparam int unsigned MAX_H          = maxpool_pkg::DEFAULT_MAX_HEIGHT;
    localparam int unsigned IDX_W          = maxpool_pkg::CFG_INDEX_BITS;
    localparam int unsigned DAT_W          = maxpool_pkg::CFG_DATA_BITS;
    localparam int unsigned LINE_SLOTS     = MAX_W / 2;
    localparam int          RESET_ITEMS    = 60;
    localparam int          CLAMP_ITEMS    = 1030;
    localparam int          RANDOM_ITEMS   = 300;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          END_CYCLES     = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DIRECTED_ROWS  = 32;

    localparam logic [IDX_W-1:0] REG_WIDTH  = maxpool_pkg::REG_FRAME_WIDTH;
    localparam logic [IDX_W-1:0] REG_HEIGHT = maxpool_pkg::REG_FRAME_HEIGHT;
    // indexes past the register list: restart the frame, change nothing else
    localparam logic [IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

    localparam logic [1:0] POS_TL = maxpool_pkg::POS_TOP_LEFT;
    localparam logic [1:0] POS_TR = maxpool_pkg::POS_TOP_RIGHT;
    localparam logic [1:0] POS_BL = maxpool_pkg::POS_BOTTOM_LEFT;
    localparam logic [1:0] POS_BR = maxpool_pkg::POS_BOTTOM_RIGHT;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pooled_max;
        logic [1:0]                 winner_pos;
        logic                       frame_end;
    } pooled_result_t;

    typedef enum logic { ROW_CONFIG, ROW_SAMPLE } row_op_t;

    typedef struct packed {
        row_op_t                     op;
        logic [IDX_W-1:0]            index;
        logic [DAT_W-1:0]            value;
        logic signed [SAMPLE_W-1:0]  smp;
        logic                        typed;
        pooled_result_t              result;
    } dir_row_t;

    localparam pooled_result_t NO_WINDOW = '0;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [SAMPLE_W-1:0]    sample;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]    pooled_max;
    logic [1:0]                    winner_pos;
    logic                          frame_end;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [IDX_W-1:0]              cfg_index;
    logic [DAT_W-1:0]              cfg_data;

    // model state
    logic signed [SAMPLE_W-1:0]    line_max [LINE_SLOTS];
    logic                          line_right [LINE_SLOTS];
    logic signed [SAMPLE_W-1:0]    run_max;
    logic                          run_right;
    int unsigned                   col_pos;
    int unsigned                   row_pos;
    logic [DAT_W-1:0]              width_reg;
    logic [DAT_W-1:0]              height_reg;

    pooled_result_t                expected_windows [$];
    int                            mismatches = 0;
    int                            quiet_cycles = 0;
    bit                            idle_on = 1'b1;
    int                            stall_left = 0;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_CONFIG, REG_WIDTH,  11'd1, 16'sd0, 1'b0, NO_WINDOW},
        '{ROW_CONFIG, REG_HEIGHT, 11'd0, 16'sd0, 1'b0, NO_WINDOW},
        // all four tied at the minimum: top-left wins
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MIN, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MIN, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MIN, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MIN, 1'b1, '{SAMPLE_MIN, POS_TL, 1'b1}},
        // top-right ties the bottom pair at the maximum
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd0,     1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MAX, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MAX, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MAX, 1'b1, '{SAMPLE_MAX, POS_TR, 1'b1}},
        // bottom-left beats a negative top pair, ties bottom-right
        '{ROW_SAMPLE, 2'd0, 11'd0, -16'sd1,    1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, -16'sd2,    1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd0,     1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd0,     1'b1, '{16'sd0, POS_BL, 1'b1}},
        // 3x3: last column and last row are dropped
        '{ROW_CONFIG, REG_WIDTH,  11'd3, 16'sd0, 1'b0, NO_WINDOW},
        '{ROW_CONFIG, REG_HEIGHT, 11'd3, 16'sd0, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd1,     1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd2,     1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MAX, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd3,     1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd4,     1'b1, '{16'sd4, POS_BR, 1'b1}},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MAX, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MAX, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MAX, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, SAMPLE_MAX, 1'b0, NO_WINDOW},
        // unmapped indexes restart the frame, the second one mid-way
        '{ROW_CONFIG, REG_UNMAPPED_2, 11'd2047, 16'sd0, 1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd10,    1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd20,    1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, -16'sd5,    1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd30,    1'b0, NO_WINDOW},
        '{ROW_SAMPLE, 2'd0, 11'd0, 16'sd40,    1'b0, NO_WINDOW},
        '{ROW_CONFIG, REG_UNMAPPED_3, 11'd0,   16'sd0, 1'b0, NO_WINDOW}
    };

    max_pool_2x2_stride2 u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pooled_max (pooled_max),
        .winner_pos (winner_pos),
        .frame_end  (frame_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int unsigned dim_in_use(input logic [DAT_W-1:0] v,
                                               input int unsigned top);
        if (v < 2)
            return 2;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic void restart_frame();
        run_max = '0;
        run_right = 1'b0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic void apply_register(input logic [IDX_W-1:0] index,
                                           input logic [DAT_W-1:0] value);
        if (index == REG_WIDTH)
            width_reg = value;
        else if (index == REG_HEIGHT)
            height_reg = value;
        restart_frame();
    endfunction

    // Advance the model by one sample; return 1 when a window completes.
    function automatic bit pool_sample(input logic signed [SAMPLE_W-1:0] s,
                                       output pooled_result_t win);
        int unsigned w, h, wu, hu, slot;
        bit          hit;
        w = dim_in_use(width_reg, MAX_W);
        h = dim_in_use(height_reg, MAX_H);
        wu = w & ~32'd1;
        hu = h & ~32'd1;
        hit = 1'b0;
        win = NO_WINDOW;
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        if (col_pos < wu && row_pos < hu)
        begin
            slot = (col_pos >> 1) % LINE_SLOTS;
            if (col_pos % 2 == 0)
            begin
                run_max = s;
                run_right = 1'b0;
            end
            else
            begin
                if (s > run_max)
                begin
                    run_max = s;
                    run_right = 1'b1;
                end
                if (row_pos % 2 == 0)
                begin
                    line_max[slot] = run_max;
                    line_right[slot] = run_right;
                end
                else
                begin
                    win.pooled_max = line_max[slot];
                    win.winner_pos = line_right[slot] ? POS_TR : POS_TL;
                    if (run_max > line_max[slot])
                    begin
                        win.pooled_max = run_max;
                        win.winner_pos = run_right ? POS_BR : POS_BL;
                    end
                    win.frame_end = (row_pos == hu - 1 && col_pos == wu - 1);
                    hit = 1'b1;
                end
            end
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
        return hit;
    endfunction

    // Mostly none, often a short gap, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2:    return SAMPLE_W'($signed($urandom_range(0, 3)) - 2);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DAT_W-1:0] random_dim();
        case ($urandom_range(0, 19))
            0:       return DAT_W'($urandom_range(0, 1));
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       return 11'd1024;
                    1:       return 11'd1025;
                    default: return 11'd2047;
                endcase
            end
            2:       return DAT_W'($urandom_range(9, 40));
            default: return DAT_W'($urandom_range(2, 8));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Called and returns at a falling edge.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit use_typed,
                               input pooled_result_t typed_win);
        int             gap;
        pooled_result_t win;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (in_stall);
        if (pool_sample(s, win) || use_typed)
            expected_windows.push_back(use_typed ? typed_win : win);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_windows.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] index,
                                  input logic [DAT_W-1:0] value);
        drain_results();
        // let a window still in the compare path settle
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (rst_n && idle_on && $urandom_range(0, 2) == 0)
        begin
            stall_left <= idle_gap();
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        pooled_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_windows.size() == 0)
            begin
                report_mismatch("pooled beat with nothing expected", int'(pooled_max), 0);
            end
            else
            begin
                want = expected_windows.pop_front();
                if (pooled_max !== want.pooled_max)
                    report_mismatch("pooled_max", int'(pooled_max), int'(want.pooled_max));
                if (winner_pos !== want.winner_pos)
                    report_mismatch("winner_pos", int'(winner_pos), int'(want.winner_pos));
                if (frame_end !== want.frame_end)
                    report_mismatch("frame_end", int'(frame_end), int'(want.frame_end));
            end
        end
    end

    // end the run when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                    || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int          sent;
        int          n;
        int          pause_at;
        int          phase;
        int unsigned frame;
        int unsigned w;
        int unsigned h;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        foreach (line_max[i])
        begin
            line_max[i] = '0;
            line_right[i] = 1'b0;
        end
        restart_frame();
        width_reg = maxpool_pkg::RESET_FRAME_DIM;
        height_reg = maxpool_pkg::RESET_FRAME_DIM;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset frame size: no window inside the first row
        for (int i = 0; i < RESET_ITEMS; i++)
            send_sample(random_sample(), 1'b0, NO_WINDOW);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_CONFIG)
                write_register(directed_rows[i].index, directed_rows[i].value);
            else
                send_sample(directed_rows[i].smp, directed_rows[i].typed,
                            directed_rows[i].result);
        end

        // oversize width clamps to the build maximum, height 1 clamps to 2;
        // fill the whole line store, then pool the first bottom-row windows
        write_register(REG_WIDTH, 11'd2047);
        write_register(REG_HEIGHT, 11'd1);
        for (int i = 0; i < CLAMP_ITEMS; i++)
            send_sample(random_sample(), 1'b0, NO_WINDOW);

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: write_register(REG_WIDTH, random_dim());
                1: write_register(REG_HEIGHT, random_dim());
                2:
                begin
                    write_register(REG_WIDTH, random_dim());
                    write_register(REG_HEIGHT, random_dim());
                end
                default:
                begin
                    write_register(REG_WIDTH, random_dim());
                    write_register(REG_HEIGHT, random_dim());
                    write_register($urandom_range(0, 1) ? REG_UNMAPPED_2 : REG_UNMAPPED_3,
                                   DAT_W'($urandom));
                end
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            w = dim_in_use(width_reg, MAX_W);
            h = dim_in_use(height_reg, MAX_H);
            frame = w * h;
            // whole frames where they are small, with a partial frame now and then
            if (frame <= 200)
            begin
                n = frame * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    n += $urandom_range(1, frame - 1);
            end
            else
            begin
                n = $urandom_range(30, 150);
            end
            pause_at = (phase == 0 || $urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
            for (int i = 0; i < n; i++)
            begin
                if (i == pause_at)
                    drain_results();
                send_sample(random_sample(), 1'b0, NO_WINDOW);
            end
            sent += n;
            phase++;
        end

        idle_on = 1'b1;
        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* max_pool_2x2_stride2.f */
+incdir+rtl/core
rtl/core/maxpool_pkg.sv
rtl/core/maxpool_ram.sv
rtl/core/max_pool_2x2_stride2.sv
rtl/core/maxpool_checker.sv
tb/sv/tb.sv
